// ----- src/i2crw_pkg.sv -----
// Shared types and constants for the I2C target register window.
// Used by every module of the block; depends on nothing else.

package i2crw_pkg;

    // Bus and sample event kinds, carried on the input tuser.
    typedef enum logic [2:0] {
        MODE_WR_ADDR = 3'd0,
        MODE_WR_DATA = 3'd1,
        MODE_RD_ADDR = 3'd2,
        MODE_RD_DATA = 3'd3,
        MODE_END     = 3'd4,
        MODE_SAMPLE  = 3'd5
    } mode_t;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam logic [7:0] PAST_END_BYTE    = 8'hFF;
    localparam logic [7:0] TABLE_RESET_BYTE = 8'hFE;
    localparam logic [7:0] COMMAND_COUNT    = 8'd2;

    // One accepted input event.
    typedef struct packed {
        logic [15:0] sample_value;
        logic [1:0]  sample_channel;
        logic [7:0]  data_byte;
        mode_t       mode;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] command_second;
        logic [7:0] command_first;
        logic       command_pending;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } result_t;

endpackage

// ----- src/i2crw_regfile.sv -----
// State of the register window (receive store, transmit table, read pointer,
// command flag) and the single-pass step logic. Depends on i2crw_pkg.

module i2crw_regfile #(
    parameter int TX_BYTES = 8,
    parameter int RX_BYTES = 3,
    parameter int CHANNELS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  i2crw_pkg::item_t  item,
    output i2crw_pkg::result_t res
);

    localparam int IDX_W = $clog2(TX_BYTES);
    localparam int POS_W = $clog2(RX_BYTES);

    logic [7:0]       rx_store_reg  [RX_BYTES];
    logic [7:0]       rx_store_next [RX_BYTES];
    logic [POS_W-1:0] rx_pos_reg;
    logic [POS_W-1:0] rx_pos_next;
    logic [7:0]       tx_table_reg  [TX_BYTES];
    logic [7:0]       tx_table_next [TX_BYTES];
    logic [7:0]       rd_ptr_reg;
    logic [7:0]       rd_ptr_next;
    logic             cmd_flag_reg;
    logic             cmd_flag_next;

    always_comb begin
        rx_store_next = rx_store_reg;
        rx_pos_next   = rx_pos_reg;
        tx_table_next = tx_table_reg;
        rd_ptr_next   = rd_ptr_reg;
        cmd_flag_next = cmd_flag_reg;
        res.tx_byte   = 8'd0;
        res.tx_valid  = 1'b0;
        case (item.mode)
            i2crw_pkg::MODE_WR_ADDR: begin
                rx_pos_next = '0;
            end
            i2crw_pkg::MODE_WR_DATA: begin
                rx_store_next[rx_pos_reg] = item.data_byte;
                rx_pos_next = (rx_pos_reg == POS_W'(RX_BYTES - 1))
                            ? '0 : rx_pos_reg + POS_W'(1);
            end
            i2crw_pkg::MODE_RD_ADDR, i2crw_pkg::MODE_RD_DATA: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = (rd_ptr_reg < 8'(TX_BYTES))
                             ? tx_table_reg[rd_ptr_reg[IDX_W-1:0]]
                             : i2crw_pkg::PAST_END_BYTE;
                rd_ptr_next  = rd_ptr_reg + 8'd1;
            end
            i2crw_pkg::MODE_END: begin
                if (8'(rx_pos_reg) == i2crw_pkg::COMMAND_COUNT) begin
                    cmd_flag_next = 1'b1;
                end else begin
                    rd_ptr_next = rx_store_reg[0];
                end
            end
            i2crw_pkg::MODE_SAMPLE: begin
                if (6'(item.sample_channel) < 6'(CHANNELS)) begin
                    for (int i = 0; i < TX_BYTES; i++) begin
                        if (7'(i) == {4'b0, item.sample_channel, 1'b0}) begin
                            tx_table_next[i] = item.sample_value[15:8];
                        end
                        if (7'(i) == {4'b0, item.sample_channel, 1'b1}) begin
                            tx_table_next[i] = item.sample_value[7:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.command_pending = cmd_flag_next;
        res.command_first   = rx_store_next[0];
        res.command_second  = rx_store_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RX_BYTES; i++) begin
                rx_store_reg[i] <= 8'd0;
            end
            for (int i = 0; i < TX_BYTES; i++) begin
                tx_table_reg[i] <= i2crw_pkg::TABLE_RESET_BYTE;
            end
            rx_pos_reg   <= '0;
            rd_ptr_reg   <= 8'd0;
            cmd_flag_reg <= 1'b0;
        end else if (step_en) begin
            rx_store_reg <= rx_store_next;
            tx_table_reg <= tx_table_next;
            rx_pos_reg   <= rx_pos_next;
            rd_ptr_reg   <= rd_ptr_next;
            cmd_flag_reg <= cmd_flag_next;
        end
    end

endmodule

// ----- src/i2c_target_register_window_core.sv -----
// A beat accepted on s_ passes through the input register, then the result register, before m_ shows it.
// Throughput: one beat per cycle while the sink takes every result beat.
// While a result waits in the result register, the input register takes at most one more beat.
// Reset (aresetn low, synchronous) empties both registers, clears the receive store,
// pointer and command flag, and fills the transmit table with 0xFE.
// Depends on i2crw_pkg and i2crw_regfile.

module i2c_target_register_window_core #(
    parameter int TX_BYTES = 8,
    parameter int RX_BYTES = 3,
    parameter int CHANNELS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: data_byte[7:0], sample_channel[9:8], sample_value[25:10], zeros above.
    input  logic [i2crw_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: mode[2:0].
    input  logic [i2crw_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: tx_byte[7:0], command_pending[8], command_first[16:9],
    // command_second[24:17], zeros above.
    output logic [i2crw_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: tx_valid[0].
    output logic [i2crw_pkg::M_TUSER_W-1:0] m_tuser
);

    // Input register: holds one accepted beat until the step logic consumes it.
    logic              in_valid_reg;
    logic              in_valid_next;
    i2crw_pkg::item_t  in_item_reg;
    i2crw_pkg::item_t  in_item_next;

    // Result register: holds one finished result until the sink takes it.
    logic               out_valid_reg;
    logic               out_valid_next;
    i2crw_pkg::result_t out_res_reg;
    i2crw_pkg::result_t out_res_next;

    i2crw_pkg::result_t step_res;
    logic               step_en;
    logic               s_fire;

    // The held beat is processed, and the state updated, exactly when its result can be
    // written into the result register: that register is empty or is being emptied now.
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_item_next.mode           = i2crw_pkg::mode_t'(s_tuser);
        in_item_next.data_byte      = s_tdata[7:0];
        in_item_next.sample_channel = s_tdata[9:8];
        in_item_next.sample_value   = s_tdata[25:10];
        in_valid_next = s_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
        out_valid_next = step_en ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_res_next   = step_res;
    end

    i2crw_regfile #(
        .TX_BYTES (TX_BYTES),
        .RX_BYTES (RX_BYTES),
        .CHANNELS (CHANNELS)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
        if (step_en) begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.command_second, out_res_reg.command_first,
                       out_res_reg.command_pending, out_res_reg.tx_byte};
    assign m_tuser  = out_res_reg.tx_valid;

endmodule

// ----- src/i2crw_checker.sv -----
// Port-level checks for the I2C target register window, and the bind that
// attaches them to i2c_target_register_window_core. Depends on i2crw_pkg.

module i2crw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [i2crw_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [i2crw_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [i2crw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [i2crw_pkg::M_TUSER_W-1:0] m_tuser
);

    // The result side is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    // A beat that is not a read carries a zero transmit byte.
    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("transmit byte set on a non-read beat");

    // The command flag, once shown, stays set in every later beat.
    a_cmd_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tdata[8]) |=> (!m_tvalid || m_tdata[8]))
        else $error("command flag dropped");

endmodule

bind i2c_target_register_window_core i2crw_checker u_i2crw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_i2c_target_register_window_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for i2c_target_register_window_core: bus and sample events go in on
// the s_ stream, and every m_ beat is checked against a behavioral model of the register window.
// Depends on i2crw_pkg and the core RTL only.

module tb_i2c_target_register_window_core;

    localparam int TABLE_BYTES = 8;
    localparam int STORE_BYTES = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_ITEMS = 215;

    // Event codes beyond the defined modes; the block must treat them as no-ops.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [i2crw_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [i2crw_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [i2crw_pkg::M_TDATA_W-1:0] m_tdata;
    logic [i2crw_pkg::M_TUSER_W-1:0] m_tuser;

    // Shadow copy of the register window state.
    logic [7:0] rx_store [STORE_BYTES];
    logic [1:0] rx_pos;
    logic [7:0] tx_table [TABLE_BYTES];
    logic [7:0] rd_ptr;
    logic       cmd_flag;

    i2crw_pkg::result_t expected_replies[$];
    int      error_count   = 0;
    int      events_sent   = 0;
    int      cycle_count   = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // The pressure test toggles hold_flip; the receiver then holds off on its own count.
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    i2c_target_register_window_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_window_model();
        foreach (rx_store[i]) rx_store[i] = 8'h00;
        foreach (tx_table[i]) tx_table[i] = i2crw_pkg::TABLE_RESET_BYTE;
        rx_pos   = 2'd0;
        rd_ptr   = 8'h00;
        cmd_flag = 1'b0;
    endfunction

    // Applies one event to the shadow state and returns the beat the block must produce.
    function automatic i2crw_pkg::result_t apply_bus_event(logic [2:0] kind,
                                                           logic [7:0] data_byte,
                                                           logic [1:0] channel,
                                                           logic [15:0] reading);
        i2crw_pkg::result_t r;
        r = '0;
        case (kind)
            i2crw_pkg::MODE_WR_ADDR: rx_pos = 2'd0;
            i2crw_pkg::MODE_WR_DATA: begin
                rx_store[rx_pos] = data_byte;
                rx_pos = (rx_pos == STORE_BYTES - 1) ? 2'd0 : rx_pos + 2'd1;
            end
            i2crw_pkg::MODE_RD_ADDR, i2crw_pkg::MODE_RD_DATA: begin
                r.tx_byte  = (rd_ptr >= TABLE_BYTES) ? i2crw_pkg::PAST_END_BYTE
                                                     : tx_table[rd_ptr];
                r.tx_valid = 1'b1;
                rd_ptr     = rd_ptr + 8'd1;
            end
            i2crw_pkg::MODE_END: begin
                // Write position two means a command; any other position sets the pointer.
                if (rx_pos == i2crw_pkg::COMMAND_COUNT)
                    cmd_flag = 1'b1;
                else
                    rd_ptr = rx_store[0];
            end
            i2crw_pkg::MODE_SAMPLE: begin
                tx_table[2 * channel]     = reading[15:8];
                tx_table[2 * channel + 1] = reading[7:0];
            end
            default: ;
        endcase
        r.command_pending = cmd_flag;
        r.command_first   = rx_store[0];
        r.command_second  = rx_store[1];
        return r;
    endfunction

    // Offers one event, after a random idle gap, and returns once it has been accepted.
    task automatic send_event(input logic [2:0] kind, input logic [7:0] data_byte,
                              input logic [1:0] channel, input logic [15:0] reading);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, reading, channel, data_byte};
        expected_replies.push_back(apply_bus_event(kind, data_byte, channel, reading));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
    endtask

    // Offers one event of the given kind with random payload fields.
    task automatic send_noisy(input logic [2:0] kind);
        send_event(kind, 8'($urandom), 2'($urandom), 16'($urandom));
    endtask

    // One bus transfer or sample burst with random content; a share of it is plain noise.
    task automatic send_random_transaction();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // Register write: address, one to four data bytes, stop.
            send_noisy(i2crw_pkg::MODE_WR_ADDR);
            n = $urandom_range(4, 1);
            repeat (n) send_noisy(i2crw_pkg::MODE_WR_DATA);
            send_noisy(i2crw_pkg::MODE_END);
        end else if (pick < 60) begin
            // Pointer write followed by a read burst; pointers mostly land near the table.
            send_noisy(i2crw_pkg::MODE_WR_ADDR);
            send_event(i2crw_pkg::MODE_WR_DATA,
                       8'(($urandom_range(3) == 0) ? $urandom
                                                   : $urandom_range(TABLE_BYTES + 1)),
                       2'($urandom), 16'($urandom));
            send_noisy(i2crw_pkg::MODE_END);
            send_noisy(i2crw_pkg::MODE_RD_ADDR);
            n = $urandom_range(9);
            repeat (n) send_noisy(i2crw_pkg::MODE_RD_DATA);
            send_noisy(i2crw_pkg::MODE_END);
        end else if (pick < 75) begin
            n = $urandom_range(4, 1);
            repeat (n) send_noisy(i2crw_pkg::MODE_SAMPLE);
        end else if (pick < 85) begin
            // Two-byte command.
            send_noisy(i2crw_pkg::MODE_WR_ADDR);
            send_noisy(i2crw_pkg::MODE_WR_DATA);
            send_noisy(i2crw_pkg::MODE_WR_DATA);
            send_noisy(i2crw_pkg::MODE_END);
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) send_noisy(3'($urandom_range(7)));
        end
    endtask

    task automatic test_reset_values();
        // The table reads 0xFE everywhere until a sample lands; entries 0 and 1 are read here.
        send_event(i2crw_pkg::MODE_RD_ADDR, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_RD_DATA, 8'hFF, 2'd3, 16'hFFFF);
    endtask

    task automatic test_sample_updates();
        send_event(i2crw_pkg::MODE_SAMPLE, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_SAMPLE, 8'hFF, 2'd1, 16'hFFFF);
        send_event(i2crw_pkg::MODE_SAMPLE, 8'h00, 2'd2, 16'hA55A);
        send_event(i2crw_pkg::MODE_SAMPLE, 8'h00, 2'd3, 16'h1234);
    endtask

    task automatic test_pointer_load();
        // The address event drops its data byte; the stop loads the pointer from entry 0.
        send_event(i2crw_pkg::MODE_WR_ADDR, 8'hFF, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_WR_DATA, 8'h06, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_END, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_RD_ADDR, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_RD_DATA, 8'h00, 2'd0, 16'h0000);
        // Pointer now sits past the end of the table.
        send_event(i2crw_pkg::MODE_RD_DATA, 8'h00, 2'd0, 16'h0000);
    endtask

    task automatic test_receive_wrap();
        send_event(i2crw_pkg::MODE_WR_ADDR, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_WR_DATA, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_WR_DATA, 8'hFF, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_WR_DATA, 8'h12, 2'd0, 16'h0000);
        // Position wrapped, so this overwrites entry 0.
        send_event(i2crw_pkg::MODE_WR_DATA, 8'h34, 2'd0, 16'h0000);
    endtask

    task automatic test_command_flag();
        // This byte brings the write position to two, so the stop raises the sticky flag.
        send_event(i2crw_pkg::MODE_WR_DATA, 8'h01, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_END, 8'h00, 2'd0, 16'h0000);
    endtask

    task automatic test_pointer_wrap();
        send_event(i2crw_pkg::MODE_WR_ADDR, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_WR_DATA, 8'hFE, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_END, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_RD_DATA, 8'h00, 2'd0, 16'h0000);
        send_event(i2crw_pkg::MODE_RD_DATA, 8'h00, 2'd0, 16'h0000);
        // Pointer has rolled over from 0xFF to zero.
        send_event(i2crw_pkg::MODE_RD_DATA, 8'h00, 2'd0, 16'h0000);
    endtask

    task automatic test_spare_modes();
        send_event(MODE_SPARE_LO, 8'hFF, 2'd3, 16'hFFFF);
        send_event(MODE_SPARE_HI, 8'hFF, 2'd3, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int start;
        start          = events_sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (events_sent - start < count) send_random_transaction();
    endtask

    task automatic test_backpressure();
        int start;
        start          = events_sent;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_flip     <= ~hold_flip;
        while (events_sent - start < 40) send_random_transaction();
    endtask

    // Receiver: random stalls, or a long hold-off when the pressure test asks for one.
    always @(posedge aclk) begin
        if (hold_flip != hold_seen) begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns mismatch on %s: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        i2crw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t ns unexpected beat: expected none, actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
                check_field("command_pending", want.command_pending, m_tdata[8]);
                check_field("command_first", want.command_first, m_tdata[16:9]);
                check_field("command_second", want.command_second, m_tdata[24:17]);
                check_field("tx_valid", want.tx_valid, m_tuser[0]);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        reset_window_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_sample_updates();
        test_pointer_load();
        test_receive_wrap();
        test_command_flag();
        test_pointer_wrap();
        test_spare_modes();

        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 46, 0);
        test_backpressure();
        test_random_traffic(PHASE_ITEMS, 0, 46);
        test_random_traffic(PHASE_ITEMS, 36, 36);

        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- i2c_target_register_window_core.f -----
src/i2crw_pkg.sv
src/i2crw_regfile.sv
src/i2c_target_register_window_core.sv
src/i2crw_checker.sv
tb/tb_i2c_target_register_window_core.sv
